// File: rtl/byte_fifo_with_line_read_macros.svh
// assertion macros shared by the checker of the byte fifo with line read
// no dependencies; included by files that hold concurrent assertions
`ifndef BYTE_FIFO_WITH_LINE_READ_MACROS_SVH
`define BYTE_FIFO_WITH_LINE_READ_MACROS_SVH

// same-cycle implication, disabled during reset
`define BFLR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BFLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bflr_pkg.sv
// shared types, codes and widths of the byte fifo with line read
// no dependencies; imported by every module of the block except bflr_ram
`timescale 1ns / 1ps

package bflr_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int MAX_BURST_DEF  = 64;
    localparam int NUM_DELIMS_DEF = 4;

    localparam int DATA_W       = 8;
    localparam int TYPE_W       = 2;
    localparam int LEN_W        = 7;
    localparam int STATUS_W     = 2;
    localparam int LEVEL_W      = 11;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 11;
    localparam int DELIM_REGS   = 4;
    localparam int DELIM_IDX_W  = 2;
    localparam int CAP_RST      = 1024;

    // request types
    localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_READ  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_LINE  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOLINE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_A  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_B  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_C  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_D  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_ADDR,
        S_RD_DATA,
        S_SCAN_ADDR,
        S_SCAN_DATA,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic                latch_req;
        logic                do_write;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                load_read;
        logic                rd_tail;
        logic                pop;
        logic                scan_start;
        logic                rd_scan;
        logic                scan_next;
        logic                load_line;
        logic                push_status;
    } t_dp_cmd;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic              read_zero;
        logic              scan_done;
        logic              byte_zero;
        logic              byte_delim;
        logic              count_last;
        logic              out_free;
    } t_dp_stat;

endpackage

// File: rtl/byte_fifo_with_line_read.sv
// top level of the byte fifo with line read: sequencer plus datapath
// depends on bflr_pkg, bflr_ctrl, bflr_dp (and bflr_ram below it)
`timescale 1ns / 1ps

// Byte ring fifo with single-byte writes, burst reads and delimiter-based line
// reads. Requests are handled one at a time; the single-port-read storage ram
// with its registered read sets the pace. A write or an empty read passes the
// exec and result states, and an unknown request type returns to idle from
// exec with no result. A read alternates an address and a data state for each
// byte that it pops. A line read scans one byte per address and data state
// pair; on a delimiter it pops the line as a read does, and a zero byte, the
// search limit or an empty fifo ends it with a no-line result. Each popped byte
// is one result transaction, and a stalled consumer holds the sequencer.
// Writing the capacity register empties the fifo; configuration must be written
// only while no request is in flight, and the block does not enforce this.
module byte_fifo_with_line_read import bflr_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int MAX_BURST  = MAX_BURST_DEF,
    parameter int NUM_DELIMS = NUM_DELIMS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [TYPE_W-1:0]     i_req_type,
    input  logic [DATA_W-1:0]     i_data_byte,
    input  logic [LEN_W-1:0]      i_req_len,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [DATA_W-1:0]     o_out_byte,
    output logic [STATUS_W-1:0]   o_out_status,
    output logic                  o_out_last,
    output logic [LEVEL_W-1:0]    o_out_level,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    bflr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bflr_dp #(
        .DEPTH      (DEPTH),
        .MAX_BURST  (MAX_BURST),
        .NUM_DELIMS (NUM_DELIMS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_type   (i_req_type),
        .i_data_byte  (i_data_byte),
        .i_req_len    (i_req_len),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_out_status (o_out_status),
        .o_out_last   (o_out_last),
        .o_out_level  (o_out_level)
    );

endmodule

// File: rtl/bflr_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bflr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bflr_ctrl.sv
// request sequencer of the byte fifo with line read
// depends on bflr_pkg; drives bflr_dp through t_dp_cmd, watches t_dp_stat
`timescale 1ns / 1ps

module bflr_ctrl import bflr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                case (i_stat.req_type)
                    REQ_WRITE: n_state = S_RESULT;
                    REQ_READ:  n_state = i_stat.read_zero ? S_RESULT : S_RD_ADDR;
                    REQ_LINE:  n_state = S_SCAN_ADDR;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_RD_ADDR: begin
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.count_last ? S_IDLE : S_RD_ADDR;
                end
            end
            S_SCAN_ADDR: begin
                n_state = i_stat.scan_done ? S_RESULT : S_SCAN_DATA;
            end
            S_SCAN_DATA: begin
                if (i_stat.byte_zero) begin
                    n_state = S_RESULT;
                end else if (i_stat.byte_delim) begin
                    n_state = S_RD_ADDR;
                end else begin
                    n_state = S_SCAN_ADDR;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.latch_req = i_in_valid;
            end
            S_EXEC: begin
                case (i_stat.req_type)
                    REQ_WRITE: o_cmd.do_write = 1'b1;
                    REQ_READ: begin
                        if (i_stat.read_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                        end else begin
                            o_cmd.load_read = 1'b1;
                        end
                    end
                    REQ_LINE: o_cmd.scan_start = 1'b1;
                    default: ;
                endcase
            end
            S_RD_ADDR: begin
                o_cmd.rd_tail = 1'b1;
            end
            S_RD_DATA: begin
                o_cmd.pop = i_stat.out_free;
            end
            S_SCAN_ADDR: begin
                if (i_stat.scan_done) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOLINE;
                end else begin
                    o_cmd.rd_scan = 1'b1;
                end
            end
            S_SCAN_DATA: begin
                if (i_stat.byte_zero) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOLINE;
                end else if (i_stat.byte_delim) begin
                    o_cmd.load_line = 1'b1;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_RESULT: begin
                o_cmd.push_status = i_stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/bflr_dp.sv
// datapath of the byte fifo with line read: ring pointers, config registers,
// scan counters, storage ram and result register; depends on bflr_pkg, bflr_ram
`timescale 1ns / 1ps

module bflr_dp import bflr_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int MAX_BURST  = MAX_BURST_DEF,
    parameter int NUM_DELIMS = NUM_DELIMS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [TYPE_W-1:0]     i_req_type,
    input  logic [DATA_W-1:0]     i_data_byte,
    input  logic [LEN_W-1:0]      i_req_len,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [DATA_W-1:0]     o_out_byte,
    output logic [STATUS_W-1:0]   o_out_status,
    output logic                  o_out_last,
    output logic [LEVEL_W-1:0]    o_out_level
);

    localparam int AW      = $clog2(DEPTH);
    localparam int SW      = ((AW > LEVEL_W) ? AW : LEVEL_W) + 1;
    localparam int LW      = $clog2(MAX_BURST + 1);
    localparam int ND      = (NUM_DELIMS < DELIM_REGS) ? NUM_DELIMS : DELIM_REGS;
    localparam int CAP_MAX = (DEPTH < 2047) ? DEPTH : 2047;
    localparam int CAP_R   = (CAP_RST < CAP_MAX) ? CAP_RST : CAP_MAX;

    logic [TYPE_W-1:0]   r_type;
    logic [DATA_W-1:0]   r_data;
    logic [LW-1:0]       r_len;
    logic [LEVEL_W-1:0]  r_cap;
    logic [DATA_W-1:0]   r_delim [DELIM_REGS];
    logic [AW-1:0]       r_tail;
    logic [LEVEL_W-1:0]  r_fill;
    logic [LW-1:0]       r_count;
    logic [LW-1:0]       r_idx;
    logic [AW-1:0]       r_scan;
    logic [STATUS_W-1:0] r_res_status;

    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_byte;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_last;
    logic [LEVEL_W-1:0]  r_out_level;

    logic [AW-1:0]       w_head;
    logic [AW-1:0]       w_tail_inc;
    logic [AW-1:0]       w_scan_inc;
    logic [LEVEL_W-1:0]  w_limit;
    logic [LW-1:0]       w_len_clamped;
    logic [LEVEL_W-1:0]  w_cap_clamped;
    logic                w_full;
    logic                w_is_delim;
    logic                w_delim_open;
    logic                w_out_free;
    logic                w_push;
    logic [DATA_W-1:0]   w_rdata;
    logic                w_ram_we;
    logic                w_ram_re;
    logic [AW-1:0]       w_ram_raddr;

    // one compare-subtract brings a sum below twice the capacity back into the ring
    function automatic logic [AW-1:0] wrap_pos(input logic [SW-1:0] s,
                                               input logic [LEVEL_W-1:0] c);
        logic [SW-1:0] cw;
        cw = SW'(c);
        if (s >= cw) begin
            return AW'(s - cw);
        end
        return AW'(s);
    endfunction

    assign w_head     = wrap_pos(SW'(r_tail) + SW'(r_fill), r_cap);
    assign w_tail_inc = wrap_pos(SW'(r_tail) + SW'(1), r_cap);
    assign w_scan_inc = wrap_pos(SW'(r_scan) + SW'(1), r_cap);
    assign w_limit    = (LEVEL_W'(r_len) < r_fill) ? LEVEL_W'(r_len) : r_fill;
    assign w_full     = (r_fill >= r_cap);

    always_comb begin
        if (i_req_len == '0) begin
            w_len_clamped = LW'(1);
        end else if (32'(i_req_len) > MAX_BURST) begin
            w_len_clamped = LW'(MAX_BURST);
        end else begin
            w_len_clamped = LW'(i_req_len);
        end
    end

    always_comb begin
        if (i_cfg_data == '0) begin
            w_cap_clamped = LEVEL_W'(1);
        end else if (32'(i_cfg_data) > CAP_MAX) begin
            w_cap_clamped = LEVEL_W'(CAP_MAX);
        end else begin
            w_cap_clamped = LEVEL_W'(i_cfg_data);
        end
    end

    // delimiter list ends at its first zero entry
    always_comb begin
        w_is_delim   = 1'b0;
        w_delim_open = 1'b1;
        for (int j = 0; j < ND; j++) begin
            if (r_delim[j] == '0) w_delim_open = 1'b0;
            if (w_delim_open && (r_delim[j] == w_rdata)) w_is_delim = 1'b1;
        end
    end

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_push      = i_cmd.pop || i_cmd.push_status;
    assign w_ram_we    = i_cmd.do_write && !w_full;
    assign w_ram_re    = i_cmd.rd_tail || i_cmd.rd_scan;
    assign w_ram_raddr = i_cmd.rd_scan ? r_scan : r_tail;

    bflr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_head),
        .i_wdata (r_data),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_rdata)
    );

    // request fields and scan state
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_type <= i_req_type;
            r_data <= i_data_byte;
            r_len  <= w_len_clamped;
        end
        if (i_cmd.do_write) begin
            r_res_status <= w_full ? ST_FULL : ST_OK;
        end else if (i_cmd.set_status) begin
            r_res_status <= i_cmd.status;
        end
        if (i_cmd.load_read) begin
            r_count <= LW'(w_limit);
        end else if (i_cmd.load_line) begin
            r_count <= r_idx + LW'(1);
        end else if (i_cmd.pop) begin
            r_count <= r_count - LW'(1);
        end
        if (i_cmd.scan_start) begin
            r_idx  <= '0;
            r_scan <= r_tail;
        end else if (i_cmd.scan_next) begin
            r_idx  <= r_idx + LW'(1);
            r_scan <= w_scan_inc;
        end
    end

    // ring pointers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= LEVEL_W'(CAP_R);
            r_tail  <= '0;
            r_fill  <= '0;
            r_delim <= '{DATA_W'(10), DATA_W'(0), DATA_W'(0), DATA_W'(0)};
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CAPACITY: begin
                        r_cap  <= w_cap_clamped;
                        r_tail <= '0;
                        r_fill <= '0;
                    end
                    REG_DELIM_A: r_delim[0] <= DATA_W'(i_cfg_data);
                    REG_DELIM_B: r_delim[1] <= DATA_W'(i_cfg_data);
                    REG_DELIM_C: r_delim[2] <= DATA_W'(i_cfg_data);
                    REG_DELIM_D: r_delim[3] <= DATA_W'(i_cfg_data);
                    default: ;
                endcase
            end
            if (w_ram_we) begin
                r_fill <= r_fill + LEVEL_W'(1);
            end else if (i_cmd.pop) begin
                r_fill <= r_fill - LEVEL_W'(1);
                r_tail <= w_tail_inc;
            end
        end
    end

    // result register, frees the sequencer from the consumer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_out_byte   <= w_rdata;
            r_out_status <= ST_OK;
            r_out_last   <= (r_count == LW'(1));
            r_out_level  <= r_fill - LEVEL_W'(1);
        end else if (i_cmd.push_status) begin
            r_out_byte   <= '0;
            r_out_status <= r_res_status;
            r_out_last   <= 1'b1;
            r_out_level  <= r_fill;
        end
    end

    assign o_stat.req_type   = r_type;
    assign o_stat.read_zero  = (r_fill == '0);
    assign o_stat.scan_done  = (LEVEL_W'(r_idx) == w_limit);
    assign o_stat.byte_zero  = (w_rdata == '0);
    assign o_stat.byte_delim = w_is_delim;
    assign o_stat.count_last = (r_count == LW'(1));
    assign o_stat.out_free   = w_out_free;

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;
    assign o_out_level  = r_out_level;

endmodule

// File: rtl/bflr_checker.sv
// port-level checker of the byte fifo with line read, bound to the top level
// depends on bflr_pkg and byte_fifo_with_line_read_macros.svh
`timescale 1ns / 1ps
`include "byte_fifo_with_line_read_macros.svh"

module bflr_checker import bflr_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [DATA_W-1:0]   o_out_byte,
    input logic [STATUS_W-1:0] o_out_status,
    input logic                o_out_last,
    input logic [LEVEL_W-1:0]  o_out_level
);

    // a stalled result transaction keeps its payload
    `BFLR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_byte) && $stable(o_out_status) && $stable(o_out_level) && $stable(o_out_last), "result changed while stalled")

    `BFLR_ASSERT_NOW(a_level_range, i_clk, i_rst_n, o_out_valid, 32'(o_out_level) <= DEPTH, "level above depth")

    // results with a status other than ok carry no byte and close the request
    `BFLR_ASSERT_NOW(a_status_last, i_clk, i_rst_n, o_out_valid && (o_out_status != ST_OK), o_out_last && (o_out_byte == '0), "status result not final or carries a byte")

    `BFLR_ASSERT_NOW(a_empty_level, i_clk, i_rst_n, o_out_valid && ((o_out_status == ST_EMPTY) || (o_out_status == ST_FULL)), (o_out_status == ST_EMPTY) == (o_out_level == '0), "empty or full status disagrees with level")

endmodule

bind byte_fifo_with_line_read bflr_checker #(
    .DEPTH (DEPTH)
) u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_byte   (o_out_byte),
    .o_out_status (o_out_status),
    .o_out_last   (o_out_last),
    .o_out_level  (o_out_level)
);

// File: sim/byte_fifo_with_line_read_test.sv
// self-checking testbench for byte_fifo_with_line_read: byte writes, burst reads, line reads
// depends on bflr_pkg and the rtl of the block; keeps its own ring model to predict results
`timescale 1ns / 1ps

module byte_fifo_with_line_read_test;
    import bflr_pkg::*;

    localparam logic [TYPE_W-1:0]    REQ_IGNORED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 3'd7;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 12;

    typedef struct packed {
        logic [TYPE_W-1:0] kind;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  len;
    } t_fifo_req;

    typedef struct packed {
        logic [DATA_W-1:0]   data;
        logic [STATUS_W-1:0] status;
        logic                last;
        logic [LEVEL_W-1:0]  level;
    } t_fifo_res;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [TYPE_W-1:0]     i_req_type = '0;
    logic [DATA_W-1:0]     i_data_byte = '0;
    logic [LEN_W-1:0]      i_req_len = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [DATA_W-1:0]     o_out_byte;
    logic [STATUS_W-1:0]   o_out_status;
    logic                  o_out_last;
    logic [LEVEL_W-1:0]    o_out_level;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    byte_fifo_with_line_read i_dut (.*);

    // ring model of the fifo
    logic [DATA_W-1:0] ring_mem [DEPTH_DEF];
    int                ring_tail = 0;
    int                ring_fill = 0;
    int                ring_cap = CAP_RST;
    logic [DATA_W-1:0] delim_list [DELIM_REGS] = '{8'd10, 8'd0, 8'd0, 8'd0};

    t_fifo_req req_backlog [$];
    t_fifo_res out_due [$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic in_taken = 1'b0;
    int  items_added = 0;
    int  items_issued = 0;
    int  items_accepted = 0;
    int  results_seen = 0;
    int  bad_results = 0;
    int  missing_results = 0;
    int  cfg_writes = 0;
    int  cycle_count = 0;
    int  status_seen [4] = '{0, 0, 0, 0};

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int ring_wrap(input int pos);
        if (pos >= ring_cap) pos -= ring_cap;
        if (pos >= DEPTH_DEF) pos = 0;
        return pos;
    endfunction

    task automatic push_result(input logic [DATA_W-1:0] data, input logic [STATUS_W-1:0] status,
                               input logic last);
        out_due.push_back('{data, status, last, LEVEL_W'(ring_fill)});
    endtask

    task automatic pop_to_results(input int n);
        int k;
        logic [DATA_W-1:0] b;
        for (k = 0; k < n; k++) begin
            b = ring_mem[ring_wrap(ring_tail)];
            ring_tail = ring_wrap(ring_tail + 1);
            ring_fill--;
            push_result(b, ST_OK, k == n - 1);
        end
    endtask

    task automatic predict_request(input logic [TYPE_W-1:0] kind, input logic [DATA_W-1:0] data,
                                   input logic [LEN_W-1:0] len_in);
        int len, lim, i, j;
        logic [DATA_W-1:0] b;
        bit stop, hit;
        len = (len_in == 0) ? 1 : ((len_in > MAX_BURST_DEF) ? MAX_BURST_DEF : int'(len_in));
        lim = (len < ring_fill) ? len : ring_fill;
        case (kind)
            REQ_WRITE: begin
                if (ring_fill < ring_cap) begin
                    ring_mem[ring_wrap(ring_tail + ring_fill)] = data;
                    ring_fill++;
                    push_result('0, ST_OK, 1'b1);
                end else begin
                    push_result('0, ST_FULL, 1'b1);
                end
            end
            REQ_READ: begin
                if (lim == 0) push_result('0, ST_EMPTY, 1'b1);
                else pop_to_results(lim);
            end
            REQ_LINE: begin
                stop = 0;
                hit = 0;
                for (i = 0; i < lim && !stop; i++) begin
                    b = ring_mem[ring_wrap(ring_tail + i)];
                    if (b == 0) begin
                        stop = 1;
                    end else begin
                        // delimiter list ends at the first zero entry
                        for (j = 0; j < DELIM_REGS && delim_list[j] != 0 && !hit; j++)
                            if (delim_list[j] == b) hit = 1;
                        if (hit) begin
                            pop_to_results(i + 1);
                            stop = 1;
                        end
                    end
                end
                if (!hit) push_result('0, ST_NOLINE, 1'b1);
            end
            default: ;
        endcase
    endtask

    task automatic add_request(input logic [TYPE_W-1:0] kind, input logic [DATA_W-1:0] data,
                               input logic [LEN_W-1:0] len);
        req_backlog.push_back('{kind, data, len});
        if (kind != REQ_IGNORED) items_added++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_writes++;
        case (idx)
            REG_CAPACITY: begin
                ring_cap = (val == 0) ? 1 : ((val > DEPTH_DEF) ? DEPTH_DEF : int'(val));
                ring_tail = 0;
                ring_fill = 0;
            end
            REG_DELIM_A: delim_list[0] = val[DATA_W-1:0];
            REG_DELIM_B: delim_list[1] = val[DATA_W-1:0];
            REG_DELIM_C: delim_list[2] = val[DATA_W-1:0];
            REG_DELIM_D: delim_list[3] = val[DATA_W-1:0];
            default: ;
        endcase
    endtask

    // block until everything sent has come back, then let ignored requests finish
    task automatic wait_drained;
        while (req_backlog.size() != 0 || items_issued != items_accepted || out_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 60) return LEN_W'($urandom_range(20, 1));
        if (r < 80) return LEN_W'($urandom_range(64, 21));
        return LEN_W'($urandom_range(127, 0));
    endfunction

    function automatic logic [DATA_W-1:0] pick_delim();
        logic [DATA_W-1:0] d;
        d = delim_list[$urandom_range(DELIM_REGS - 1)];
        if (d == 0) d = delim_list[0];
        if (d == 0) d = 8'h0A;
        return d;
    endfunction

    // sender: new transaction only once the previous one was taken
    always @(negedge i_clk) begin : drive_requests
        t_fifo_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = req_backlog.pop_front();
                i_in_valid <= 1'b1;
                i_req_type <= nxt.kind;
                i_data_byte <= nxt.data;
                i_req_len <= nxt.len;
                items_issued++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // results are checked before the accepted request is predicted
    always @(posedge i_clk) begin : check_and_predict
        t_fifo_res due;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                status_seen[o_out_status]++;
                if (out_due.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("%0t: result with none pending: byte %02h status %0d last %0d level %0d",
                                 $realtime, o_out_byte, o_out_status, o_out_last, o_out_level);
                end else begin
                    due = out_due.pop_front();
                    if (o_out_byte !== due.data || o_out_status !== due.status ||
                        o_out_last !== due.last || o_out_level !== due.level) begin
                        bad_results++;
                        if (bad_results <= 10) begin
                            $display("%0t: mismatch: expected byte %02h status %0d last %0d level %0d",
                                     $realtime, due.data, due.status, due.last, due.level);
                            $display("    got byte %02h status %0d last %0d level %0d",
                                     o_out_byte, o_out_status, o_out_last, o_out_level);
                        end
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                predict_request(i_req_type, i_data_byte, i_req_len);
                items_accepted++;
            end
        end
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending", cycle_count,
                     out_due.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int cap_plan [6];
        logic [DATA_W-1:0] delim_plan [6][DELIM_REGS];
        int idle_plan [4];
        int stall_plan [4];
        int p, i, k, r, quota;

        cap_plan = '{2047, 5, 1024, 33, 1, 700};
        delim_plan = '{
            '{8'd10, 8'd13, 8'h3B, 8'hFF},
            '{8'd10, 8'd0, 8'd13, 8'h20},
            '{8'd0, 8'd10, 8'd13, 8'd0},
            '{8'hFF, 8'h80, 8'h01, 8'h7F},
            '{8'd10, 8'd0, 8'd0, 8'd0},
            '{8'd10, 8'd13, 8'd0, 8'h20}};
        idle_plan = '{0, 60, 0, 6};
        stall_plan = '{0, 0, 60, 6};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty fifo, length clamps, line found, zero byte, search limit
        add_request(REQ_READ, 8'h00, 7'd0);
        add_request(REQ_LINE, 8'h00, 7'd5);
        add_request(REQ_WRITE, 8'h41, 7'd127);
        add_request(REQ_WRITE, 8'hFF, 7'd0);
        add_request(REQ_WRITE, 8'd10, 7'd1);
        add_request(REQ_LINE, 8'h00, 7'd127);
        add_request(REQ_WRITE, 8'h00, 7'd64);
        add_request(REQ_WRITE, 8'd10, 7'd64);
        add_request(REQ_LINE, 8'hFF, 7'd64);
        add_request(REQ_READ, 8'h00, 7'd0);
        add_request(REQ_LINE, 8'h00, 7'd1);
        for (i = 0; i < 4; i++) add_request(REQ_WRITE, DATA_W'(8'h31 + i), 7'd3);
        add_request(REQ_LINE, 8'h00, 7'd2);
        add_request(REQ_READ, 8'h00, 7'd127);
        add_request(REQ_IGNORED, 8'hFF, 7'd127);
        add_request(REQ_READ, 8'h00, 7'd1);
        wait_drained();

        // zero capacity behaves as one byte
        write_reg(REG_CAPACITY, 11'd0);
        add_request(REQ_WRITE, 8'h5A, 7'd1);
        add_request(REQ_WRITE, 8'hA5, 7'd1);
        add_request(REQ_LINE, 8'h00, 7'd1);
        add_request(REQ_READ, 8'h00, 7'd64);
        wait_drained();

        for (p = 0; p < 6; p++) begin
            write_reg(REG_CAPACITY, CFG_DATA_W'(cap_plan[p]));
            write_reg(REG_DELIM_A, CFG_DATA_W'(delim_plan[p][0]));
            write_reg(REG_DELIM_B, CFG_DATA_W'(delim_plan[p][1]));
            write_reg(REG_DELIM_C, CFG_DATA_W'(delim_plan[p][2]));
            write_reg(REG_DELIM_D, CFG_DATA_W'(delim_plan[p][3]));
            if (p == 0) write_reg(REG_SPARE, 11'h7FF);
            send_idle_pct = idle_plan[p % 4];
            recv_stall_pct = stall_plan[p % 4];

            quota = items_added + 35;
            while (items_added < quota) begin
                r = $urandom_range(99);
                if (r < 50) begin
                    // a line of text, mostly closed by a delimiter
                    k = $urandom_range(12, 1);
                    for (i = 0; i < k; i++)
                        add_request(REQ_WRITE, DATA_W'($urandom_range(255, 1)), pick_len());
                    r = $urandom_range(9);
                    if (r < 7) add_request(REQ_WRITE, pick_delim(), pick_len());
                    else if (r < 8) add_request(REQ_WRITE, 8'h00, pick_len());
                end else if (r < 72) begin
                    add_request(REQ_LINE, DATA_W'($urandom_range(255)), pick_len());
                end else if (r < 88) begin
                    add_request(REQ_READ, DATA_W'($urandom_range(255)), pick_len());
                end else if (r < 95) begin
                    add_request(REQ_WRITE, DATA_W'($urandom_range(255)), pick_len());
                end else begin
                    add_request(REQ_IGNORED, DATA_W'($urandom_range(255)),
                                LEN_W'($urandom_range(127)));
                end
            end
            wait_drained();
        end

        missing_results = out_due.size();
        if (missing_results != 0)
            $display("%0d expected results never arrived", missing_results);
        $display("covered %0d requests and %0d results over %0d register writes",
                 items_accepted, results_seen, cfg_writes);
        $display("status counts: ok %0d, full %0d, empty %0d, no line %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (bad_results == 0 && missing_results == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
